>>> rtl/etpd_pkg.sv
`default_nettype none

package etpd_pkg;

  // Default vertex capacity of the seen matrix.
  localparam int MAX_VERTICES_DEF = 64;

  // Fixed field widths.
  localparam int VC_W    = 7;
  localparam int VERT_W  = 7;
  localparam int COUNT_W = 32;
  localparam logic [VC_W-1:0] VERTEX_COUNT_RST = 7'd64;

  // Character codes that the token grammar uses.
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Input and result kinds.
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_EOS  = 1'b1;
  localparam logic RES_EDGE  = 1'b0;
  localparam logic RES_SUMM  = 1'b1;

  // Token parser phases.
  typedef enum logic [2:0] {
    PH_START,
    PH_FIRST,
    PH_SECOND,
    PH_DONE,
    PH_REJECT
  } phase_t;

  // Events that the parser raises for the item it takes in this cycle.
  typedef struct packed {
    logic edge_hit;
    logic eos_hit;
    logic empty;
  } parse_evt_t;

endpackage

`default_nettype wire

>>> rtl/etpd_parser.sv
`default_nettype none

module etpd_parser #(
  parameter int MAX_VERTICES = etpd_pkg::MAX_VERTICES_DEF,
  parameter int NUM_W        = $clog2(MAX_VERTICES + 2)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         fire,
  input  wire logic                         kind,
  input  wire logic [7:0]                   char_code,
  input  wire logic [etpd_pkg::VC_W-1:0]    vertex_count,
  output etpd_pkg::parse_evt_t              evt,
  output logic [NUM_W-1:0]                  owner,
  output logic [NUM_W-1:0]                  neighbor,
  output logic [etpd_pkg::COUNT_W-1:0]      count
);

  localparam int ACC_W = NUM_W + 4;
  localparam int CMP_W = (NUM_W > etpd_pkg::VC_W) ? NUM_W : etpd_pkg::VC_W;
  localparam logic [NUM_W-1:0] NUM_SAT = NUM_W'(MAX_VERTICES + 1);
  localparam logic [NUM_W-1:0] NUM_MAX = NUM_W'(MAX_VERTICES);

  etpd_pkg::phase_t                 phase_r, phase_nxt;
  logic [NUM_W-1:0]                 first_r, first_nxt;
  logic [NUM_W-1:0]                 second_r, second_nxt;
  logic [etpd_pkg::COUNT_W-1:0]     count_r, count_nxt;
  logic                             is_digit;
  logic                             is_delim;

  // Decimal accumulate that saturates just above the vertex range.
  function automatic logic [NUM_W-1:0] add_digit(input logic [NUM_W-1:0] acc,
                                                 input logic [3:0] dig);
    logic [ACC_W-1:0] sum;
    sum = ACC_W'(acc) * ACC_W'(10) + ACC_W'(dig);
    if (acc >= NUM_SAT || sum > ACC_W'(NUM_SAT)) begin
      return NUM_SAT;
    end
    return NUM_W'(sum);
  endfunction

  // A number is in range when it lies in 1..min(vertex_count, capacity).
  function automatic logic in_range(input logic [NUM_W-1:0] v,
                                    input logic [etpd_pkg::VC_W-1:0] vc);
    return (v != '0) && (CMP_W'(v) <= CMP_W'(vc)) && (v <= NUM_MAX);
  endfunction

  assign is_digit = (char_code >= etpd_pkg::CH_ZERO) && (char_code <= etpd_pkg::CH_NINE);
  assign is_delim = (char_code == etpd_pkg::CH_SPACE) || (char_code == etpd_pkg::CH_TAB) ||
                    (char_code == etpd_pkg::CH_LF);

  // Token state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= etpd_pkg::PH_START;
      first_r  <= '0;
      second_r <= '0;
      count_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      count_r  <= count_nxt;
    end
  end

  // Next token state and the event for the item taken in this cycle.
  always_comb begin
    phase_nxt    = phase_r;
    first_nxt    = first_r;
    second_nxt   = second_r;
    count_nxt    = count_r;
    evt.edge_hit = 1'b0;
    evt.eos_hit  = 1'b0;
    evt.empty    = (count_r == '0);
    owner        = second_r;
    neighbor     = first_r;
    if (fire) begin
      if (kind == etpd_pkg::KIND_EOS) begin
        evt.eos_hit = 1'b1;
        phase_nxt   = etpd_pkg::PH_START;
        first_nxt   = '0;
        second_nxt  = '0;
      end else if (is_delim) begin
        // Both numbers were range-checked on the way into the done phase.
        if (phase_r == etpd_pkg::PH_DONE) begin
          evt.edge_hit = 1'b1;
          if (count_r != '1) begin
            count_nxt = count_r + 1'b1;
          end
        end
        phase_nxt  = etpd_pkg::PH_START;
        first_nxt  = '0;
        second_nxt = '0;
      end else begin
        unique case (phase_r)
          etpd_pkg::PH_START: begin
            phase_nxt = (char_code == etpd_pkg::CH_OPEN) ? etpd_pkg::PH_FIRST
                                                         : etpd_pkg::PH_REJECT;
          end
          etpd_pkg::PH_FIRST: begin
            if (is_digit) begin
              first_nxt = add_digit(first_r, char_code[3:0]);
            end else if (char_code == etpd_pkg::CH_COMMA) begin
              phase_nxt = in_range(first_r, vertex_count) ? etpd_pkg::PH_SECOND
                                                          : etpd_pkg::PH_REJECT;
            end else if (char_code != etpd_pkg::CH_CLOSE) begin
              phase_nxt = etpd_pkg::PH_REJECT;
            end
          end
          etpd_pkg::PH_SECOND: begin
            if (is_digit) begin
              second_nxt = add_digit(second_r, char_code[3:0]);
            end else if (char_code == etpd_pkg::CH_CLOSE) begin
              phase_nxt = in_range(second_r, vertex_count) ? etpd_pkg::PH_DONE
                                                           : etpd_pkg::PH_REJECT;
            end else begin
              phase_nxt = etpd_pkg::PH_REJECT;
            end
          end
          etpd_pkg::PH_DONE: begin
            phase_nxt = etpd_pkg::PH_DONE;
          end
          default: begin
            phase_nxt = etpd_pkg::PH_REJECT;
          end
        endcase
      end
    end
    // Edge results carry the count that includes this edge.
    count = count_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/etpd_seen_mem.sv
`default_nettype none

module etpd_seen_mem #(
  parameter int MAX_VERTICES = etpd_pkg::MAX_VERTICES_DEF,
  parameter int ROW_W        = $clog2(MAX_VERTICES)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    rd_en,
  input  wire logic [ROW_W-1:0]        rd_addr,
  input  wire logic                    wr_en,
  input  wire logic [ROW_W-1:0]        wr_addr,
  input  wire logic [MAX_VERTICES-1:0] wr_data,
  output logic [MAX_VERTICES-1:0]      rd_data_r,
  output logic                         clearing
);

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAX_VERTICES - 1);

  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic                    clearing_r;
  logic [ROW_W-1:0]        clr_idx_r;

  assign clearing = clearing_r;

  // Clearing pass after reset, one row per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clearing_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == LAST_ROW) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // One write port shared by the clearing pass and the row update.
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/edge_token_parser_dedup.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_kind, in_char_code
// out_      output     out_valid / out_ready  out_result_kind .. out_empty_input
// cfg_      input      cfg_we                 cfg_wdata (vertex_count)
//
// One item is accepted per cycle while in_ready is high; a result passes
// through the stage register and the output register. The rate is set by the
// token parser and one row read per edge. After reset a clearing pass zeroes
// the seen matrix row by row; in_ready stays low during it, configuration
// writes are taken as ever. Apart from that pass, in_ready drops only while a
// result waits in the stage register and the output register is stalled.
`default_nettype none

module edge_token_parser_dedup #(
  parameter int MAX_VERTICES = etpd_pkg::MAX_VERTICES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_kind,
  input  wire logic [7:0]                      in_char_code,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_result_kind,
  output logic [etpd_pkg::VERT_W-1:0]          out_owner_vertex,
  output logic [etpd_pkg::VERT_W-1:0]          out_neighbor_vertex,
  output logic                                 out_is_new,
  output logic [etpd_pkg::COUNT_W-1:0]         out_edge_count,
  output logic                                 out_empty_input,
  input  wire logic                            cfg_we,
  input  wire logic [etpd_pkg::VC_W-1:0]       cfg_wdata
);

  localparam int NUM_W = $clog2(MAX_VERTICES + 2);
  localparam int ROW_W = $clog2(MAX_VERTICES);

  logic [etpd_pkg::VC_W-1:0]     vertex_count_r;
  logic                          fire;
  logic                          clearing;
  logic                          s1_adv;
  etpd_pkg::parse_evt_t          evt;
  logic [NUM_W-1:0]              p_owner;
  logic [NUM_W-1:0]              p_neighbor;
  logic [etpd_pkg::COUNT_W-1:0]  p_count;
  logic [MAX_VERTICES-1:0]       rd_row;
  logic [MAX_VERTICES-1:0]       wr_row;
  logic [ROW_W-1:0]              s1_col;
  logic                          s1_fresh;
  logic                          wr_en;

  logic                          s1_valid_r;
  logic                          s1_kind_r;
  logic [NUM_W-1:0]              s1_owner_r;
  logic [NUM_W-1:0]              s1_neighbor_r;
  logic [etpd_pkg::COUNT_W-1:0]  s1_count_r;
  logic                          s1_empty_r;
  logic                          out_valid_r;
  logic                          out_kind_r;
  logic [etpd_pkg::VERT_W-1:0]   out_owner_r;
  logic [etpd_pkg::VERT_W-1:0]   out_neighbor_r;
  logic                          out_new_r;
  logic [etpd_pkg::COUNT_W-1:0]  out_count_r;
  logic                          out_empty_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= etpd_pkg::VERTEX_COUNT_RST;
    end else if (cfg_we) begin
      vertex_count_r <= cfg_wdata;
    end
  end

  // Handshake: the stage register must have room for a possible result.
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !clearing && (!s1_valid_r || s1_adv);
  assign fire     = in_valid && in_ready;

  etpd_parser #(
    .MAX_VERTICES (MAX_VERTICES),
    .NUM_W        (NUM_W)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .kind         (in_kind),
    .char_code    (in_char_code),
    .vertex_count (vertex_count_r),
    .evt          (evt),
    .owner        (p_owner),
    .neighbor     (p_neighbor),
    .count        (p_count)
  );

  // Row update: test the neighbor bit and set it as the result moves on.
  assign s1_col   = ROW_W'(s1_neighbor_r - 1'b1);
  assign s1_fresh = !rd_row[s1_col];
  assign wr_row   = rd_row | (MAX_VERTICES'(1) << s1_col);
  assign wr_en    = s1_valid_r && s1_adv && (s1_kind_r == etpd_pkg::RES_EDGE);

  etpd_seen_mem #(
    .MAX_VERTICES (MAX_VERTICES),
    .ROW_W        (ROW_W)
  ) u_seen (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (evt.edge_hit),
    .rd_addr   (ROW_W'(p_owner - 1'b1)),
    .wr_en     (wr_en),
    .wr_addr   (ROW_W'(s1_owner_r - 1'b1)),
    .wr_data   (wr_row),
    .rd_data_r (rd_row),
    .clearing  (clearing)
  );

  // Stage register: holds a result while its matrix row is read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (evt.edge_hit || evt.eos_hit) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt.edge_hit || evt.eos_hit) begin
      s1_kind_r     <= evt.eos_hit ? etpd_pkg::RES_SUMM : etpd_pkg::RES_EDGE;
      s1_owner_r    <= p_owner;
      s1_neighbor_r <= p_neighbor;
      s1_count_r    <= p_count;
      s1_empty_r    <= evt.empty;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_kind_r  <= s1_kind_r;
      out_count_r <= s1_count_r;
      if (s1_kind_r == etpd_pkg::RES_EDGE) begin
        out_owner_r    <= etpd_pkg::VERT_W'(s1_owner_r);
        out_neighbor_r <= etpd_pkg::VERT_W'(s1_neighbor_r);
        out_new_r      <= s1_fresh;
        out_empty_r    <= 1'b0;
      end else begin
        out_owner_r    <= '0;
        out_neighbor_r <= '0;
        out_new_r      <= 1'b0;
        out_empty_r    <= s1_empty_r;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_kind_r;
  assign out_owner_vertex    = out_owner_r;
  assign out_neighbor_vertex = out_neighbor_r;
  assign out_is_new          = out_new_r;
  assign out_edge_count      = out_count_r;
  assign out_empty_input     = out_empty_r;

endmodule

`default_nettype wire

>>> rtl/etpd_checker.sv
`default_nettype none

module etpd_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic                         out_result_kind,
  input wire logic [etpd_pkg::VERT_W-1:0]  out_owner_vertex,
  input wire logic [etpd_pkg::VERT_W-1:0]  out_neighbor_vertex,
  input wire logic                         out_is_new,
  input wire logic [etpd_pkg::COUNT_W-1:0] out_edge_count,
  input wire logic                         out_empty_input
);

  // A stalled result keeps its valid and its count.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_edge_count))
    else $error("stalled result changed");

  // The clearing pass blocks input right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during clearing pass");

  // A summary carries zeroed edge fields and flags an empty count.
  a_summary_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == etpd_pkg::RES_SUMM |->
      out_owner_vertex == '0 && out_neighbor_vertex == '0 && !out_is_new &&
      out_empty_input == (out_edge_count == '0))
    else $error("bad summary result");

  // An edge result never flags empty input and has counted itself.
  a_edge_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == etpd_pkg::RES_EDGE |->
      !out_empty_input && out_edge_count != '0)
    else $error("bad edge result");

endmodule

bind edge_token_parser_dedup etpd_checker u_etpd_checker (.*);

`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_V = etpd_pkg::MAX_VERTICES_DEF;
  localparam int NUM_SAT = MAX_V + 1;
  localparam int RECV_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int MAX_REPORTED = 100;

  typedef logic [etpd_pkg::VERT_W-1:0] vnum_t;
  typedef logic [etpd_pkg::VC_W-1:0] vcount_t;

  // One result of the block, field by field.
  typedef struct packed {
    logic                         rkind;
    vnum_t                        owner;
    vnum_t                        neighbor;
    logic                         fresh;
    logic [etpd_pkg::COUNT_W-1:0] count;
    logic                         empty;
  } edge_report_t;

  // One row of the directed stimulus table.
  typedef struct {
    logic         kind;
    logic [7:0]   ch;
    logic         typed;
    edge_report_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = etpd_pkg::KIND_TEXT;
  logic [7:0] in_char_code = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_result_kind;
  vnum_t out_owner_vertex;
  vnum_t out_neighbor_vertex;
  logic out_is_new;
  logic [etpd_pkg::COUNT_W-1:0] out_edge_count;
  logic out_empty_input;
  logic cfg_we = 1'b0;
  vcount_t cfg_wdata = etpd_pkg::VERTEX_COUNT_RST;
  logic hold_req = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count = 0;
  int items_sent = 0;
  int stall_cycles = 0;

  // Parser state as the testbench expects it.
  etpd_pkg::phase_t tok_phase = etpd_pkg::PH_START;
  vnum_t first_num = '0;
  vnum_t second_num = '0;
  logic [etpd_pkg::COUNT_W-1:0] edge_total = '0;
  logic [MAX_V-1:0] seen_pairs [MAX_V];
  vcount_t vertex_cfg = etpd_pkg::VERTEX_COUNT_RST;

  edge_report_t expected_reports [$];
  stim_row_t stim_rows [$];
  logic [7:0] tok_bytes [$];

  edge_token_parser_dedup i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_char_code        (in_char_code),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_result_kind     (out_result_kind),
    .out_owner_vertex    (out_owner_vertex),
    .out_neighbor_vertex (out_neighbor_vertex),
    .out_is_new          (out_is_new),
    .out_edge_count      (out_edge_count),
    .out_empty_input     (out_empty_input),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic logic is_delim(input logic [7:0] ch);
    return ch == etpd_pkg::CH_SPACE || ch == etpd_pkg::CH_TAB || ch == etpd_pkg::CH_LF;
  endfunction

  // Appends a decimal digit; the number saturates one above the vertex range.
  function automatic vnum_t next_number(input vnum_t acc, input logic [7:0] ch);
    int nxt;
    if (int'(acc) >= NUM_SAT) return vnum_t'(NUM_SAT);
    nxt = int'(acc) * 10 + int'(ch) - int'(etpd_pkg::CH_ZERO);
    return (nxt > NUM_SAT) ? vnum_t'(NUM_SAT) : vnum_t'(nxt);
  endfunction

  // Advances the expected parser state by one item and gives the result it causes.
  function automatic void parse_item(input logic kind, input logic [7:0] ch,
                                     output logic got, output edge_report_t rep);
    int lim;
    logic hit;
    logic digit;
    vnum_t own;
    vnum_t nbr;
    got = 1'b0;
    rep = '0;
    lim = (int'(vertex_cfg) < MAX_V) ? int'(vertex_cfg) : MAX_V;
    digit = ch >= etpd_pkg::CH_ZERO && ch <= etpd_pkg::CH_NINE;
    if (kind == etpd_pkg::KIND_EOS) begin
      tok_phase = etpd_pkg::PH_START;
      first_num = '0;
      second_num = '0;
      got = 1'b1;
      rep.rkind = etpd_pkg::RES_SUMM;
      rep.count = edge_total;
      rep.empty = (edge_total == 0);
    end else if (is_delim(ch)) begin
      hit = (tok_phase == etpd_pkg::PH_DONE);
      own = second_num;
      nbr = first_num;
      tok_phase = etpd_pkg::PH_START;
      first_num = '0;
      second_num = '0;
      if (hit && own >= 1 && int'(own) <= MAX_V && nbr >= 1 && int'(nbr) <= MAX_V) begin
        rep.fresh = !seen_pairs[own - 1][nbr - 1];
        seen_pairs[own - 1][nbr - 1] = 1'b1;
        if (edge_total != '1) edge_total = edge_total + 1;
        got = 1'b1;
        rep.rkind = etpd_pkg::RES_EDGE;
        rep.owner = own;
        rep.neighbor = nbr;
        rep.count = edge_total;
      end
    end else begin
      case (tok_phase)
        etpd_pkg::PH_START: begin
          tok_phase = (ch == etpd_pkg::CH_OPEN) ? etpd_pkg::PH_FIRST : etpd_pkg::PH_REJECT;
        end
        etpd_pkg::PH_FIRST: begin
          if (digit) begin
            first_num = next_number(first_num, ch);
          end else if (ch == etpd_pkg::CH_COMMA) begin
            tok_phase = (first_num >= 1 && int'(first_num) <= lim) ? etpd_pkg::PH_SECOND
                                                                   : etpd_pkg::PH_REJECT;
          end else if (ch != etpd_pkg::CH_CLOSE) begin
            tok_phase = etpd_pkg::PH_REJECT;
          end
        end
        etpd_pkg::PH_SECOND: begin
          if (digit) begin
            second_num = next_number(second_num, ch);
          end else if (ch == etpd_pkg::CH_CLOSE) begin
            tok_phase = (second_num >= 1 && int'(second_num) <= lim) ? etpd_pkg::PH_DONE
                                                                     : etpd_pkg::PH_REJECT;
          end else begin
            tok_phase = etpd_pkg::PH_REJECT;
          end
        end
        etpd_pkg::PH_DONE: begin
        end
        default: begin
          tok_phase = etpd_pkg::PH_REJECT;
        end
      endcase
    end
  endfunction

  function automatic void add_row(input logic kind, input logic [7:0] ch,
                                  input logic typed, input edge_report_t want);
    stim_row_t row;
    row.kind = kind;
    row.ch = ch;
    row.typed = typed;
    row.want = want;
    stim_rows.push_back(row);
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_row(etpd_pkg::KIND_TEXT, s[i], 1'b0, '0);
  endfunction

  // Any byte that does not end a token.
  function automatic logic [7:0] junk_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (is_delim(b));
    return b;
  endfunction

  // Picks a token number; -1 stands for no digits at all.
  function automatic int pick_number(input int lim);
    int r;
    int top;
    r = $urandom_range(99);
    top = (lim < 1) ? 1 : lim;
    if (r < 45) return $urandom_range(1, (top < 6) ? top : 6);
    if (r < 75) return $urandom_range(1, top);
    if (r < 83) return lim + 1;
    if (r < 88) return 0;
    if (r < 93) return -1;
    return $urandom_range(65, 99999999);
  endfunction

  function automatic void push_number(input int v);
    string digits;
    if (v < 0) return;
    if ($urandom_range(7) == 0) begin
      repeat ($urandom_range(1, 2)) tok_bytes.push_back(etpd_pkg::CH_ZERO);
    end
    digits = $sformatf("%0d", v);
    for (int i = 0; i < digits.len(); i++) tok_bytes.push_back(digits[i]);
  endfunction

  // Builds one token and its delimiter, mostly well formed.
  function automatic void build_token(input int lim);
    int style;
    int a;
    int b;
    style = $urandom_range(99);
    a = pick_number(lim);
    b = pick_number(lim);
    tok_bytes.delete();
    if (style >= 96) begin
      // An empty token is the delimiter alone.
    end else if (style >= 91) begin
      // The token does not open with a parenthesis.
      tok_bytes.push_back(junk_byte());
      push_number(a);
      tok_bytes.push_back(etpd_pkg::CH_COMMA);
      push_number(b);
      tok_bytes.push_back(etpd_pkg::CH_CLOSE);
    end else begin
      tok_bytes.push_back(etpd_pkg::CH_OPEN);
      if ($urandom_range(9) == 0) tok_bytes.push_back(etpd_pkg::CH_CLOSE);
      push_number(a);
      // Styles 70 to 75 lose the comma, 76 to 81 lose the closing parenthesis.
      if (style < 70 || style >= 76) begin
        tok_bytes.push_back(etpd_pkg::CH_COMMA);
        push_number(b);
      end
      if (style < 76 || style >= 82) tok_bytes.push_back(etpd_pkg::CH_CLOSE);
      if ($urandom_range(7) == 0) tok_bytes.push_back(junk_byte());
      // Styles from 82 get one byte overwritten.
      if (style >= 82) tok_bytes[$urandom_range(tok_bytes.size() - 1)] = junk_byte();
    end
    case ($urandom_range(2))
      0: tok_bytes.push_back(etpd_pkg::CH_SPACE);
      1: tok_bytes.push_back(etpd_pkg::CH_TAB);
      default: tok_bytes.push_back(etpd_pkg::CH_LF);
    endcase
  endfunction

  // Offers one item, waits for it to be taken and records the result it should cause.
  task automatic put_item(input logic kind, input logic [7:0] ch,
                          input logic typed, input edge_report_t want);
    logic got;
    edge_report_t pred;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_char_code <= ch;
    do @(posedge clk); while (!in_ready);
    parse_item(kind, ch, got, pred);
    if (typed) begin
      expected_reports.push_back(want);
    end else if (got) begin
      expected_reports.push_back(pred);
    end
    items_sent++;
  endtask

  // Stops sending and lets every expected result and any item in flight pass.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input vcount_t value);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    vertex_cfg = value;
  endtask

  // Sends random tokens; now and then end of stream cuts one short.
  task automatic run_random(input int count);
    int goal;
    int lim;
    int stop_at;
    goal = items_sent + count;
    while (items_sent < goal) begin
      lim = (int'(vertex_cfg) < MAX_V) ? int'(vertex_cfg) : MAX_V;
      build_token(lim);
      stop_at = tok_bytes.size();
      if ($urandom_range(24) == 0) stop_at = $urandom_range(tok_bytes.size() - 1);
      for (int i = 0; i < stop_at; i++) begin
        put_item(etpd_pkg::KIND_TEXT, tok_bytes[i], 1'b0, '0);
      end
      if (stop_at < tok_bytes.size() || $urandom_range(49) == 0) begin
        put_item(etpd_pkg::KIND_EOS, 8'($urandom_range(255)), 1'b0, '0);
      end
    end
  endtask

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      if (error_count < MAX_REPORTED) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
      error_count++;
    end
  endfunction

  // The receiver stalls at random, and once holds off for a long stretch on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req <= 1'b0;
        out_ready <= 1'b0;
        repeat (RECV_HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Each result taken is compared with the oldest one expected.
  always @(posedge clk) begin : check_results
    edge_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        if (error_count < MAX_REPORTED) begin
          $display("%0t: result with nothing expected, kind %0d owner %0d neighbor %0d",
                   $time, out_result_kind, out_owner_vertex, out_neighbor_vertex);
        end
        error_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("result_kind", 32'(want.rkind), 32'(out_result_kind));
        check_field("owner_vertex", 32'(want.owner), 32'(out_owner_vertex));
        check_field("neighbor_vertex", 32'(want.neighbor), 32'(out_neighbor_vertex));
        check_field("is_new", 32'(want.fresh), 32'(out_is_new));
        check_field("edge_count", want.count, out_edge_count);
        check_field("empty_input", 32'(want.empty), 32'(out_empty_input));
      end
    end
  end

  // The run ends when no item moves on either side for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    foreach (seen_pairs[v]) seen_pairs[v] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items: extremes, tolerated parentheses, empty and cut tokens, odd bytes.
    send_idle_pct = 9;
    recv_idle_pct = 76;
    add_row(etpd_pkg::KIND_EOS, 8'hFF, 1'b1,
            '{etpd_pkg::RES_SUMM, 7'd0, 7'd0, 1'b0, 32'd0, 1'b1});
    add_text("(64,1)");
    add_row(etpd_pkg::KIND_TEXT, etpd_pkg::CH_SPACE, 1'b1,
            '{etpd_pkg::RES_EDGE, 7'd1, 7'd64, 1'b1, 32'd1, 1'b0});
    add_text("()1,064)");
    add_row(etpd_pkg::KIND_TEXT, etpd_pkg::CH_TAB, 1'b1,
            '{etpd_pkg::RES_EDGE, 7'd64, 7'd1, 1'b1, 32'd2, 1'b0});
    add_row(etpd_pkg::KIND_TEXT, etpd_pkg::CH_LF, 1'b0, '0);
    add_text("(999");
    add_row(etpd_pkg::KIND_EOS, 8'h00, 1'b1,
            '{etpd_pkg::RES_SUMM, 7'd0, 7'd0, 1'b0, 32'd2, 1'b0});
    add_row(etpd_pkg::KIND_TEXT, 8'hFF, 1'b0, '0);
    add_row(etpd_pkg::KIND_TEXT, 8'h00, 1'b0, '0);
    add_row(etpd_pkg::KIND_TEXT, etpd_pkg::CH_LF, 1'b0, '0);
    foreach (stim_rows[i]) begin
      put_item(stim_rows[i].kind, stim_rows[i].ch, stim_rows[i].typed, stim_rows[i].want);
    end

    // Sender mostly busy, receiver mostly stalled.
    write_vertex_count(7'd5);
    run_random(450);

    // Sender mostly idle, receiver mostly ready; the smallest vertex counts.
    send_idle_pct = 76;
    recv_idle_pct = 9;
    write_vertex_count(7'd1);
    run_random(300);
    write_vertex_count(7'd0);
    run_random(150);

    // Full rate on both sides, starting with a long receiver hold-off.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_vertex_count(7'd127);
    hold_req <= 1'b1;
    run_random(300);
    write_vertex_count(7'd64);
    run_random(300);
    write_vertex_count(vcount_t'($urandom_range(2, 63)));
    run_random(300);

    settle();
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/etpd_pkg.sv
rtl/etpd_parser.sv
rtl/etpd_seen_mem.sv
rtl/edge_token_parser_dedup.sv
rtl/etpd_checker.sv
bench/tb_top.sv
